/* rtl/core/csrb_pkg.sv */
// Shared types and constants for the sorted edge list to CSR builder.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package csrb_pkg;

	localparam int NODE_BITS  = 16;
	localparam int EDGE_BITS  = 20;
	localparam int ID_BITS    = 24;
	localparam int PTR_BITS   = 2;
	localparam int FIFO_DEPTH = 1 << PTR_BITS;
	localparam int REG_BITS   = 2;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [REG_BITS-1:0] REG_NODE_COUNT    = 2'd0;
	localparam logic [REG_BITS-1:0] REG_SOURCE_OFFSET = 2'd1;
	localparam logic [REG_BITS-1:0] REG_DEST_OFFSET   = 2'd2;

	typedef enum logic [1:0] {
		KIND_COLUMN = 2'd0,
		KIND_RANGE  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] node_count;
		logic [ID_BITS-1:0]   source_offset;
		logic [ID_BITS-1:0]   dest_offset;
	} cfg_t;

	// One queue entry: an optional node range followed by an optional tail result
	typedef struct packed {
		logic                 has_range;
		logic [NODE_BITS-1:0] first_node;
		logic [NODE_BITS-1:0] last_node;
		logic [EDGE_BITS:0]   row_start;
		logic                 has_tail;
		kind_t                tail_kind;
		logic [EDGE_BITS-1:0] entry_index;
		logic [NODE_BITS-1:0] column;
	} work_t;

	typedef struct packed {
		kind_t                kind;
		logic [EDGE_BITS-1:0] entry_index;
		logic [NODE_BITS-1:0] column;
		logic [NODE_BITS-1:0] first_node;
		logic [NODE_BITS-1:0] last_node;
		logic [EDGE_BITS:0]   row_start;
		logic                 last_result;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/csrb_front.sv */
// Front end: relabels and checks each accepted item and tracks the row state.
// Depends on csrb_pkg.
`default_nettype none
module csrb_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire csrb_pkg::cfg_t                  cfg,
	input  wire logic                            accept,
	input  wire logic                            operation,
	input  wire logic [csrb_pkg::ID_BITS-1:0]    source_node,
	input  wire logic [csrb_pkg::ID_BITS-1:0]    dest_node,
	output csrb_pkg::work_t                      work
);

	logic [csrb_pkg::NODE_BITS-1:0] prev_source_q;
	logic [csrb_pkg::EDGE_BITS:0]   edges_seen_q;
	logic                           any_edge_q;

	logic [csrb_pkg::ID_BITS-1:0]   rel_src;
	logic [csrb_pkg::ID_BITS-1:0]   rel_dst;
	logic                           src_bad;
	logic                           dst_bad;
	logic                           unsorted;
	logic                           overflow;
	logic                           edge_err;
	logic [csrb_pkg::NODE_BITS-1:0] range_first;
	logic [csrb_pkg::EDGE_BITS:0]   range_start;

	assign rel_src  = source_node - cfg.source_offset;
	assign rel_dst  = dest_node - cfg.dest_offset;
	assign src_bad  = (source_node < cfg.source_offset)
		|| (rel_src >= csrb_pkg::ID_BITS'(cfg.node_count));
	assign dst_bad  = (dest_node < cfg.dest_offset)
		|| (|rel_dst[csrb_pkg::ID_BITS-1:csrb_pkg::NODE_BITS]);
	assign unsorted = any_edge_q && (rel_src[csrb_pkg::NODE_BITS-1:0] < prev_source_q);
	assign overflow = edges_seen_q[csrb_pkg::EDGE_BITS];
	assign edge_err = src_bad || dst_bad || unsorted || overflow;

	assign range_first = any_edge_q ? prev_source_q + 1'b1 : '0;
	assign range_start = any_edge_q ? edges_seen_q : '0;

	always_comb begin
		work = '0;
		if (operation == csrb_pkg::OP_END) begin
			work.has_range  = 1'b1;
			work.first_node = range_first;
			work.last_node  = cfg.node_count;
			work.row_start  = range_start;
			work.has_tail   = 1'b0;
			work.tail_kind  = csrb_pkg::KIND_COLUMN;
		end else if (edge_err) begin
			work.has_tail  = 1'b1;
			work.tail_kind = csrb_pkg::KIND_ERROR;
		end else begin
			work.has_range   = !any_edge_q
				|| (rel_src[csrb_pkg::NODE_BITS-1:0] != prev_source_q);
			work.first_node  = range_first;
			work.last_node   = rel_src[csrb_pkg::NODE_BITS-1:0];
			work.row_start   = range_start;
			work.has_tail    = 1'b1;
			work.tail_kind   = csrb_pkg::KIND_COLUMN;
			work.entry_index = edges_seen_q[csrb_pkg::EDGE_BITS-1:0];
			work.column      = rel_dst[csrb_pkg::NODE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_source_q <= '0;
			edges_seen_q  <= '0;
			any_edge_q    <= 1'b0;
		end else if (accept) begin
			if (operation == csrb_pkg::OP_END) begin
				prev_source_q <= '0;
				edges_seen_q  <= '0;
				any_edge_q    <= 1'b0;
			end else if (!edge_err) begin
				prev_source_q <= rel_src[csrb_pkg::NODE_BITS-1:0];
				edges_seen_q  <= edges_seen_q + 1'b1;
				any_edge_q    <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/csrb_fifo.sv */
// Short queue of classified work between the front end and the back end.
// Depends on csrb_pkg.
`default_nettype none
module csrb_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire csrb_pkg::work_t wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output logic                 rd_valid,
	output csrb_pkg::work_t      rd_data
);

	csrb_pkg::work_t                 mem_q [csrb_pkg::FIFO_DEPTH];
	logic [csrb_pkg::PTR_BITS-1:0]   wr_ptr_q;
	logic [csrb_pkg::PTR_BITS-1:0]   rd_ptr_q;
	logic [csrb_pkg::PTR_BITS:0]     count_q;

	assign full     = (count_q == (csrb_pkg::PTR_BITS+1)'(csrb_pkg::FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/csrb_back.sv */
// Back end: expands queued work into result transactions in an output register.
// Depends on csrb_pkg.
`default_nettype none
module csrb_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire csrb_pkg::work_t head,
	output logic                 head_take,
	input  wire logic            pop,
	output logic                 empty,
	output csrb_pkg::result_t    res
);

	logic              out_valid_q;
	logic              phase_q;
	csrb_pkg::result_t res_q;
	csrb_pkg::result_t next_res;
	logic              load;
	logic              emit_range;

	assign load       = head_valid && (!out_valid_q || pop);
	assign emit_range = head.has_range && !phase_q;
	assign head_take  = load && !(emit_range && head.has_tail);
	assign empty      = !out_valid_q;
	assign res        = res_q;

	always_comb begin
		next_res = '0;
		if (emit_range) begin
			next_res.kind        = csrb_pkg::KIND_RANGE;
			next_res.first_node  = head.first_node;
			next_res.last_node   = head.last_node;
			next_res.row_start   = head.row_start;
			next_res.last_result = !head.has_tail;
		end else begin
			next_res.kind        = head.tail_kind;
			next_res.entry_index = head.entry_index;
			next_res.column      = head.column;
			next_res.last_result = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= emit_range && head.has_tail;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sorted_edges_to_csr_builder.sv */
// Top level of the sorted edge list to CSR builder: configuration registers,
// front end, work queue and back end. Depends on csrb_pkg, csrb_front,
// csrb_fifo and csrb_back.
//
// Input side is a queue write: an item (operation, source_node, dest_node)
// is taken at a clock edge with push high and full low. Results come out as a
// queue read: while empty is low the oldest result is on the result ports and
// it is taken at a clock edge with pop high. Configuration writes arrive on
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// An accepted item is classified in the same cycle and written into the work
// queue; the back end loads it from the queue head into the output register
// whenever that register is empty or its result is being popped.
// An item yields one result (error, end range, or column entry) or two (node
// range, then column entry); the single output register holds one result at
// a time, so while pop stays high one-result items sustain one item per cycle,
// and a two-result item leaves the queue head only when its column entry is
// loaded. A four-entry work queue absorbs stalls on the result side; full
// rises once it and the output register are occupied.
// Reset clears the registers, the row state and the queue.
`default_nettype none
module sorted_edges_to_csr_builder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [csrb_pkg::REG_BITS-1:0]     cfg_index,
	input  wire logic [csrb_pkg::ID_BITS-1:0]      cfg_data,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              operation,
	input  wire logic [csrb_pkg::ID_BITS-1:0]      source_node,
	input  wire logic [csrb_pkg::ID_BITS-1:0]      dest_node,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [1:0]                             kind,
	output logic [csrb_pkg::EDGE_BITS-1:0]         entry_index,
	output logic [csrb_pkg::NODE_BITS-1:0]         column,
	output logic [csrb_pkg::NODE_BITS-1:0]         first_node,
	output logic [csrb_pkg::NODE_BITS-1:0]         last_node,
	output logic [csrb_pkg::EDGE_BITS:0]           row_start,
	output logic                                   last_result
);

	csrb_pkg::cfg_t    cfg_q;
	csrb_pkg::work_t   work;
	csrb_pkg::work_t   head;
	csrb_pkg::result_t res;
	logic              accept;
	logic              head_valid;
	logic              head_take;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csrb_pkg::REG_NODE_COUNT:
					cfg_q.node_count <= cfg_data[csrb_pkg::NODE_BITS-1:0];
				csrb_pkg::REG_SOURCE_OFFSET:
					cfg_q.source_offset <= cfg_data;
				csrb_pkg::REG_DEST_OFFSET:
					cfg_q.dest_offset <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	csrb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.operation   (operation),
		.source_node (source_node),
		.dest_node   (dest_node),
		.work        (work)
	);

	csrb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (work),
		.full     (full),
		.rd_en    (head_take),
		.rd_valid (head_valid),
		.rd_data  (head)
	);

	csrb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_take  (head_take),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign kind        = res.kind;
	assign entry_index = res.entry_index;
	assign column      = res.column;
	assign first_node  = res.first_node;
	assign last_node   = res.last_node;
	assign row_start   = res.row_start;
	assign last_result = res.last_result;

endmodule
`default_nettype wire

/* tb/csrb_checker.sv */
// Checker for the CSR builder: watches the register, item and result channels,
// predicts every result from the accepted items and compares field by field.
// Depends on csrb_pkg.
`timescale 1ns / 1ps
module csrb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [csrb_pkg::REG_BITS-1:0] cfg_index,
	input  logic [csrb_pkg::ID_BITS-1:0]  cfg_data,
	input  logic                          push,
	input  logic                          full,
	input  logic                          operation,
	input  logic [csrb_pkg::ID_BITS-1:0]  source_node,
	input  logic [csrb_pkg::ID_BITS-1:0]  dest_node,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [1:0]                    kind,
	input  logic [csrb_pkg::EDGE_BITS-1:0] entry_index,
	input  logic [csrb_pkg::NODE_BITS-1:0] column,
	input  logic [csrb_pkg::NODE_BITS-1:0] first_node,
	input  logic [csrb_pkg::NODE_BITS-1:0] last_node,
	input  logic [csrb_pkg::EDGE_BITS:0]   row_start,
	input  logic                          last_result,
	output int                            mismatches,
	output int                            pending
);
	import csrb_pkg::*;

	logic [NODE_BITS-1:0] nodes      = '0;
	logic [ID_BITS-1:0]   src_base   = '0;
	logic [ID_BITS-1:0]   dst_base   = '0;
	logic [NODE_BITS-1:0] prev_row   = '0;
	logic [EDGE_BITS:0]   edge_total = '0;
	logic                 seen_edge  = 1'b0;
	result_t              csr_due[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic derive_csr_results(input logic op, input logic [ID_BITS-1:0] src,
			input logic [ID_BITS-1:0] dst);
		logic [ID_BITS-1:0] rel_src;
		logic [ID_BITS-1:0] rel_dst;
		result_t            r;
		r = '0;
		rel_src = src - src_base;
		rel_dst = dst - dst_base;
		if (op == OP_END) begin
			r.kind = KIND_RANGE;
			r.last_node = nodes;
			r.last_result = 1'b1;
			if (seen_edge) begin
				r.first_node = prev_row + 1'b1;
				r.row_start = edge_total;
			end
			csr_due.push_back(r);
			prev_row = '0;
			edge_total = '0;
			seen_edge = 1'b0;
		end else if (src < src_base || dst < dst_base || rel_src >= nodes ||
				(rel_dst >> NODE_BITS) != '0 || (seen_edge && rel_src < prev_row) ||
				edge_total >= (1 << EDGE_BITS)) begin
			r.kind = KIND_ERROR;
			r.last_result = 1'b1;
			csr_due.push_back(r);
		end else begin
			if (!seen_edge || rel_src[NODE_BITS-1:0] != prev_row) begin
				r.kind = KIND_RANGE;
				r.first_node = seen_edge ? prev_row + 1'b1 : '0;
				r.last_node = rel_src[NODE_BITS-1:0];
				r.row_start = seen_edge ? edge_total : '0;
				csr_due.push_back(r);
				r = '0;
			end
			r.kind = KIND_COLUMN;
			r.entry_index = edge_total[EDGE_BITS-1:0];
			r.column = rel_dst[NODE_BITS-1:0];
			r.last_result = 1'b1;
			csr_due.push_back(r);
			prev_row = rel_src[NODE_BITS-1:0];
			edge_total = edge_total + 1'b1;
			seen_edge = 1'b1;
		end
	endtask

	always @(posedge clk) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			nodes = '0;
			src_base = '0;
			dst_base = '0;
			prev_row = '0;
			edge_total = '0;
			seen_edge = 1'b0;
			csr_due.delete();
		end else begin
			if (pop && !empty) begin
				got.kind = kind_t'(kind);
				got.entry_index = entry_index;
				got.column = column;
				got.first_node = first_node;
				got.last_node = last_node;
				got.row_start = row_start;
				got.last_result = last_result;
				if (csr_due.size() == 0) begin
					report_mismatch("result transaction with no result due");
				end else begin
					want = csr_due.pop_front();
					if (got !== want)
						report_mismatch($sformatf({"result mismatch: got kind %0d idx %0d col %0d",
							" range %0d..%0d start %0d last %0d; due kind %0d idx %0d col %0d",
							" range %0d..%0d start %0d last %0d"},
							got.kind, got.entry_index, got.column, got.first_node,
							got.last_node, got.row_start, got.last_result, want.kind,
							want.entry_index, want.column, want.first_node, want.last_node,
							want.row_start, want.last_result));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NODE_COUNT: nodes = cfg_data[NODE_BITS-1:0];
					REG_SOURCE_OFFSET: src_base = cfg_data;
					REG_DEST_OFFSET: dst_base = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				derive_csr_results(operation, source_node, dest_node);
		end
		pending = csr_due.size();
	end

endmodule

/* tb/tb.sv */
// Testbench top for sorted_edges_to_csr_builder: clock, reset, register writes,
// directed and random edge lists, and the verdict. Depends on csrb_pkg,
// csrb_checker and the RTL under rtl/core.
`timescale 1ns / 1ps
module tb;
	import csrb_pkg::*;

	localparam logic [REG_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int ID_MAX = (1 << ID_BITS) - 1;
	localparam int NODE_MAX = (1 << NODE_BITS) - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_BITS-1:0]  cfg_index = '0;
	logic [ID_BITS-1:0]   cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 operation = OP_EDGE;
	logic [ID_BITS-1:0]   source_node = '0;
	logic [ID_BITS-1:0]   dest_node = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [1:0]           kind;
	logic [EDGE_BITS-1:0] entry_index;
	logic [NODE_BITS-1:0] column;
	logic [NODE_BITS-1:0] first_node;
	logic [NODE_BITS-1:0] last_node;
	logic [EDGE_BITS:0]   row_start;
	logic                 last_result;
	int                   mismatches;
	int                   pending;

	int send_idle = 0;
	int pop_idle = 0;
	int node_lim = 0;
	int src_base = 0;
	int dst_base = 0;

	always #4 clk = ~clk;

	always @(negedge clk)
		pop <= ($urandom_range(99) >= pop_idle);

	sorted_edges_to_csr_builder u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push), .full(full), .operation(operation), .source_node(source_node),
		.dest_node(dest_node),
		.empty(empty), .pop(pop), .kind(kind), .entry_index(entry_index),
		.column(column), .first_node(first_node), .last_node(last_node),
		.row_start(row_start), .last_result(last_result)
	);

	csrb_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push), .full(full), .operation(operation), .source_node(source_node),
		.dest_node(dest_node),
		.empty(empty), .pop(pop), .kind(kind), .entry_index(entry_index),
		.column(column), .first_node(first_node), .last_node(last_node),
		.row_start(row_start), .last_result(last_result),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	task automatic push_item(input logic op, input int src, input int dst);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		operation <= op;
		source_node <= ID_BITS'(src);
		dest_node <= ID_BITS'(dst);
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// hold off until every due result has come back
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_BITS-1:0] idx, input int data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ID_BITS'(data);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input int n, input int sb, input int db);
		settle();
		write_reg(REG_NODE_COUNT, n);
		write_reg(REG_SOURCE_OFFSET, sb);
		write_reg(REG_DEST_OFFSET, db);
		node_lim = n;
		src_base = sb;
		dst_base = db;
	endtask

	task automatic directed();
		configure(100, 10, 5);
		push_item(OP_END, 0, 0);
		push_item(OP_EDGE, 10, 5);
		push_item(OP_EDGE, 10, 5 + NODE_MAX);
		push_item(OP_EDGE, 10, 5 + NODE_MAX + 1);
		push_item(OP_EDGE, 9, 6);
		push_item(OP_EDGE, 11, 4);
		push_item(OP_EDGE, 110, 6);
		push_item(OP_EDGE, 15, 7);
		push_item(OP_EDGE, 12, 7);
		push_item(OP_EDGE, 109, 5);
		push_item(OP_END, ID_MAX, ID_MAX);
		push_item(OP_EDGE, ID_MAX, ID_MAX);
		configure(NODE_MAX, 0, 0);
		push_item(OP_EDGE, 0, 0);
		push_item(OP_EDGE, NODE_MAX - 1, NODE_MAX);
		push_item(OP_EDGE, NODE_MAX, 0);
		push_item(OP_EDGE, NODE_MAX - 1, ID_MAX);
		push_item(OP_END, 0, 0);
		configure(0, 0, 0);
		push_item(OP_EDGE, 0, 0);
		push_item(OP_END, 0, 0);
		configure(1, ID_MAX, ID_MAX);
		write_reg(REG_UNUSED, ID_MAX);
		push_item(OP_EDGE, ID_MAX, ID_MAX);
		push_item(OP_EDGE, ID_MAX - 1, ID_MAX);
		push_item(OP_END, 0, 0);
	endtask

	task automatic pick_config();
		int n;
		int sb;
		int db;
		case ($urandom_range(7))
			0: n = NODE_MAX;
			1: n = $urandom_range(0, 1);
			2: n = $urandom_range(1, NODE_MAX);
			default: n = $urandom_range(2, 300);
		endcase
		case ($urandom_range(3))
			0: sb = 0;
			1: sb = ID_MAX - n;
			default: sb = $urandom_range(0, ID_MAX - n);
		endcase
		case ($urandom_range(7))
			0: db = 0;
			1: db = ID_MAX - NODE_MAX;
			2: db = ID_MAX - $urandom_range(0, 3);
			default: db = $urandom_range(0, ID_MAX - NODE_MAX);
		endcase
		configure(n, sb, db);
	endtask

	task automatic send_list(input int len);
		int rs;
		int rmax;
		int dmax;
		int roll;
		int src;
		int dst;
		rmax = node_lim - 1;
		dmax = (ID_MAX - dst_base < NODE_MAX) ? ID_MAX - dst_base : NODE_MAX;
		rs = (rmax > 0) ? $urandom_range(0, (rmax < 4) ? rmax : 4) : 0;
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			src = src_base + rs;
			dst = dst_base + $urandom_range(0, dmax);
			if (roll < 75 && rmax >= 0) begin
				if ($urandom_range(3) == 0)
					rs += $urandom_range(1, 1 + rmax / 8);
				if (rs > rmax)
					rs = rmax;
				src = src_base + rs;
			end else if (roll < 82 && rs > 0) begin
				src = src_base + $urandom_range(0, rs - 1);
			end else if (roll < 88) begin
				if (src_base > 0 && $urandom_range(1) == 0)
					src = $urandom_range(0, src_base - 1);
				else
					src = src_base + node_lim + $urandom_range(0, 15);
				if (src > ID_MAX)
					src = ID_MAX;
			end else if (roll < 93) begin
				if (dst_base > 0 && $urandom_range(1) == 0)
					dst = $urandom_range(0, dst_base - 1);
				else
					dst = dst_base + NODE_MAX + 1 + $urandom_range(0, 255);
				if (dst > ID_MAX)
					dst = (dst_base > 0) ? dst_base - 1 : ID_MAX;
			end else begin
				src = $urandom_range(0, ID_MAX);
				dst = $urandom_range(0, ID_MAX);
			end
			push_item(OP_EDGE, src, dst);
		end
		push_item(OP_END, $urandom_range(0, ID_MAX), $urandom_range(0, ID_MAX));
	endtask

	task automatic random_phase(input int quota);
		int sent;
		int len;
		sent = 0;
		while (sent < quota) begin
			pick_config();
			repeat (3) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 40);
				send_list(len);
				sent += len + 1;
			end
		end
	endtask

	initial begin : stimulus
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		send_idle = 12;
		pop_idle = 78;
		directed();
		random_phase(650);
		settle();
		send_idle = 78;
		pop_idle = 12;
		random_phase(650);
		settle();
		send_idle = 0;
		pop_idle = 0;
		random_phase(650);
		settle();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
